// ===== design/dtcd_pkg.sv =====
// Package for the day-count to calendar-date converter.
// Holds the reciprocal constant, the year-start and leap-year tables, and the month tables.
// No dependencies.
package dtcd_pkg;

   localparam int unsigned EPOCH_YEAR       = 1970;
   localparam int unsigned YEAR_RECIP_SHIFT = 24;
   // ceil(2^24 / 365): exact quotient for every 16-bit day count.
   localparam logic [15:0] YEAR_RECIP       = 16'd45965;

   typedef logic [16:0]    year_start_type;
   typedef year_start_type year_start_table_type [0:255];
   typedef logic [255:0]   leap_table_type;
   typedef logic [8:0]     month_end_table_type [0:11];

   // Year starts are built by stepping counters for the 4, 100 and 400 year cycles.
   function automatic year_start_table_type build_year_start();
      year_start_table_type tbl;
      logic [16:0]          acc;
      logic                 leap;
      int                   c4;
      int                   c100;
      int                   c400;
      acc  = '0;
      c4   = 2;
      c100 = 70;
      c400 = 370;
      for (int i = 0; i < 256; i++) begin
         tbl[i] = acc;
         leap   = (c4 == 0) && ((c100 != 0) || (c400 == 0));
         acc    = acc + 17'd365 + {16'd0, leap};
         c4     = (c4 == 3) ? 0 : c4 + 1;
         c100   = (c100 == 99) ? 0 : c100 + 1;
         c400   = (c400 == 399) ? 0 : c400 + 1;
      end
      return tbl;
   endfunction

   function automatic leap_table_type build_leap_table();
      leap_table_type tbl;
      int             c4;
      int             c100;
      int             c400;
      c4   = 2;
      c100 = 70;
      c400 = 370;
      for (int i = 0; i < 256; i++) begin
         tbl[i] = (c4 == 0) && ((c100 != 0) || (c400 == 0));
         c4     = (c4 == 3) ? 0 : c4 + 1;
         c100   = (c100 == 99) ? 0 : c100 + 1;
         c400   = (c400 == 399) ? 0 : c400 + 1;
      end
      return tbl;
   endfunction

   localparam year_start_table_type YEAR_START = build_year_start();
   localparam leap_table_type       LEAP_YEAR  = build_leap_table();

   localparam month_end_table_type MONTH_END_NORMAL = '{
      9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
   };
   localparam month_end_table_type MONTH_END_LEAP = '{
      9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
      9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
   };
   localparam month_end_table_type MONTH_START_NORMAL = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };
   localparam month_end_table_type MONTH_START_LEAP = '{
      9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
   };

endpackage

// ===== design/days_to_calendar_date.sv =====
// Day count since 1970-01-01 to Gregorian year, month and day of month.
// An accepted request passes the stage 1, stage 2 and output registers before its response is valid.
// Throughput is one transaction per cycle; a stalled response holds every full stage.
// Stages: reciprocal multiply, year correction against the year-start table, month search.
// Synchronous reset clears the stage valid bits only; data registers are not reset.
// Depends on dtcd_pkg.
module days_to_calendar_date (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_day_number,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day_of_month
);

   // Stage enables: a stage loads when it is empty or its content moves on.
   logic en_out;
   logic en_s2;
   logic en_s1;

   // Stage 1: year estimate by reciprocal multiply.
   logic        s1_valid_ff;
   logic [15:0] s1_day_ff;
   logic [7:0]  s1_quot_ff;
   logic [31:0] s1_prod;
   logic [7:0]  s1_quot_in;

   // Stage 2: corrected year offset and day of year.
   logic        s2_valid_ff;
   logic [7:0]  s2_offset_ff;
   logic [8:0]  s2_doy_ff;
   logic        s2_leap_ff;
   logic [7:0]  s2_offset_in;
   logic [8:0]  s2_doy_in;
   logic        s2_leap_in;
   logic [16:0] s2_start_hi;
   logic [16:0] s2_start_lo;
   logic        s2_corr;
   logic [16:0] s2_diff;

   // Stage 3: output registers.
   logic        rsp_valid_ff;
   logic [11:0] rsp_year_ff;
   logic [3:0]  rsp_month_ff;
   logic [4:0]  rsp_dom_ff;
   logic [11:0] rsp_year_in;
   logic [3:0]  rsp_month_in;
   logic [4:0]  rsp_dom_in;
   logic [8:0]  s3_month_start;
   logic [8:0]  s3_dom_wide;

   assign en_out    = !rsp_valid_ff || rsp_ready;
   assign en_s2     = !s2_valid_ff || en_out;
   assign en_s1     = !s1_valid_ff || en_s2;
   assign req_ready = en_s1;

   assign s1_prod    = 32'(req_day_number) * 32'(dtcd_pkg::YEAR_RECIP);
   assign s1_quot_in = s1_prod[dtcd_pkg::YEAR_RECIP_SHIFT +: 8];

   // The estimate is at most one year high; the previous start is read alongside.
   assign s2_start_hi  = dtcd_pkg::YEAR_START[s1_quot_ff];
   assign s2_start_lo  = dtcd_pkg::YEAR_START[s1_quot_ff - 8'd1];
   assign s2_corr      = (s1_quot_ff != 8'd0) && ({1'b0, s1_day_ff} < s2_start_hi);
   assign s2_offset_in = s2_corr ? (s1_quot_ff - 8'd1) : s1_quot_ff;
   assign s2_diff      = {1'b0, s1_day_ff} - (s2_corr ? s2_start_lo : s2_start_hi);
   assign s2_doy_in    = s2_diff[8:0];
   assign s2_leap_in   = dtcd_pkg::LEAP_YEAR[s2_offset_in];

   // The first month whose cumulative end exceeds the day of year wins.
   always_comb begin
      rsp_month_in   = 4'd12;
      s3_month_start = s2_leap_ff ? dtcd_pkg::MONTH_START_LEAP[11]
                                  : dtcd_pkg::MONTH_START_NORMAL[11];
      for (int i = 11; i >= 0; i--) begin
         if (s2_leap_ff ? (s2_doy_ff < dtcd_pkg::MONTH_END_LEAP[i])
                        : (s2_doy_ff < dtcd_pkg::MONTH_END_NORMAL[i])) begin
            rsp_month_in   = 4'(i + 1);
            s3_month_start = s2_leap_ff ? dtcd_pkg::MONTH_START_LEAP[i]
                                        : dtcd_pkg::MONTH_START_NORMAL[i];
         end
      end
   end

   assign s3_dom_wide = s2_doy_ff - s3_month_start + 9'd1;
   assign rsp_dom_in  = s3_dom_wide[4:0];
   assign rsp_year_in = 12'(dtcd_pkg::EPOCH_YEAR) + {4'd0, s2_offset_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_s1) begin
            s1_valid_ff <= req_valid;
         end
         if (en_s2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (en_out) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_s1) begin
         s1_day_ff  <= req_day_number;
         s1_quot_ff <= s1_quot_in;
      end
      if (en_s2) begin
         s2_offset_ff <= s2_offset_in;
         s2_doy_ff    <= s2_doy_in;
         s2_leap_ff   <= s2_leap_in;
      end
      if (en_out) begin
         rsp_year_ff  <= rsp_year_in;
         rsp_month_ff <= rsp_month_in;
         rsp_dom_ff   <= rsp_dom_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_year         = rsp_year_ff;
   assign rsp_month        = rsp_month_ff;
   assign rsp_day_of_month = rsp_dom_ff;

   // The year estimate never goes past the last year of the range.
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_quot_ff <= 8'd179))
      else $error("year estimate out of range");

   // Request side only stalls when every stage holds a transaction.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff))
      else $error("request stalled with an empty stage");

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_year >= 12'd1970) && (rsp_year <= 12'd2149))
      else $error("year out of range");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= 4'd1) && (rsp_month <= 4'd12)
                    && (rsp_day_of_month != 5'd0))
      else $error("month or day of month out of range");

   // February never runs past its 29th day.
   a_february: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_month == 4'd2)) |-> (rsp_day_of_month <= 5'd29))
      else $error("February day out of range");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for days_to_calendar_date, the day-count to calendar-date converter.
// Predicts year, month and day of month from the day count and checks every response in order.
// Depends on dtcd_pkg and the days_to_calendar_date module.
module tb_top;

   localparam int unsigned YEAR_SPAN    = 180;
   localparam int unsigned RANDOM_ITEMS = 1330;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  mday;
   } civil_date_type;

   typedef struct {
      logic [15:0]    day_number;
      civil_date_type date;
   } date_expectation_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [15:0] req_day_number = '0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day_of_month;

   logic [15:0]          day_stream [$];
   date_expectation_type pending_dates [$];
   int unsigned       total_items     = 0;
   int unsigned       directed_items  = 0;
   int unsigned       sent_count      = 0;
   int unsigned       checked_count   = 0;
   int unsigned       failures        = 0;
   int unsigned       cycle_count     = 0;
   logic              results_idle    = 1'b1;
   logic [YEAR_SPAN-1:0] years_seen   = '0;
   int unsigned       leap_days_seen  = 0;

   days_to_calendar_date uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_day_number   (req_day_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month)
   );

   always #1 clock = ~clock;

   function automatic bit gregorian_leap(int unsigned yr);
      return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
   endfunction

   // Leap days in the years before yr, counted from year 1.
   function automatic int unsigned leaps_before(int unsigned yr);
      return (yr - 1) / 4 - (yr - 1) / 100 + (yr - 1) / 400;
   endfunction

   function automatic int unsigned first_day_of_year(int unsigned yr);
      return 365 * (yr - dtcd_pkg::EPOCH_YEAR) + leaps_before(yr)
             - leaps_before(dtcd_pkg::EPOCH_YEAR);
   endfunction

   // Days in the year before the first of month mon; mon may be 13 for the year length.
   function automatic int unsigned days_before_month(int unsigned mon, bit leap);
      int unsigned lengths [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      int unsigned total;
      total = 0;
      for (int m = 1; m < mon; m++) begin
         total += lengths[m-1] + ((m == 2 && leap) ? 1 : 0);
      end
      return total;
   endfunction

   function automatic logic [15:0] date_to_days(int unsigned yr, int unsigned mon,
                                                int unsigned mday);
      int unsigned days;
      days = first_day_of_year(yr) + days_before_month(mon, gregorian_leap(yr)) + mday - 1;
      return days[15:0];
   endfunction

   function automatic civil_date_type convert_days(logic [15:0] days);
      civil_date_type date;
      int unsigned    yr;
      int unsigned    doy;
      int unsigned    mon;
      bit             leap;
      yr = dtcd_pkg::EPOCH_YEAR + days / 365;
      // The quotient overshoots by at most one year near the end of a year.
      if (days < first_day_of_year(yr)) begin
         yr--;
      end
      doy  = days - first_day_of_year(yr);
      leap = gregorian_leap(yr);
      mon  = 1;
      while (mon < 12 && doy >= days_before_month(mon + 1, leap)) begin
         mon++;
      end
      date.year  = 12'(yr);
      date.month = 4'(mon);
      date.mday  = 5'(doy - days_before_month(mon, leap) + 1);
      return date;
   endfunction

   // Half of the random day counts sit on year, month and February boundaries; the rest are uniform or near the top.
   function automatic logic [15:0] random_day_number();
      int unsigned yr;
      int unsigned days;
      yr = dtcd_pkg::EPOCH_YEAR + $urandom_range(YEAR_SPAN - 1);
      case ($urandom_range(9))
         0, 1, 2, 3: days = $urandom_range(16'hFFFF);
         4, 5:       days = first_day_of_year(yr) + $urandom_range(4) - 2;
         6, 7:       days = date_to_days(yr, $urandom_range(1, 12), 1) + $urandom_range(2) - 1;
         8: begin
            case ($urandom_range(2))
               0:       yr = 2000;
               1:       yr = 2100;
               default: yr = 1972 + 4 * $urandom_range(44);
            endcase
            days = date_to_days(yr, 2, 27) + $urandom_range(3);
         end
         default:    days = 16'hFFFF - $urandom_range(200);
      endcase
      return days[15:0];
   endfunction

   function automatic int unsigned idle_percent(int unsigned count, bit receiver);
      int unsigned phase;
      phase = (total_items == 0) ? 0 : count * 3 / total_items;
      case (phase)
         0:       return receiver ? 79 : 16;
         1:       return receiver ? 16 : 79;
         default: return 0;
      endcase
   endfunction

   function automatic bit is_drain_point(int unsigned count);
      return count != 0 && (count == directed_items || count == total_items / 2);
   endfunction

   // Request driver.
   always @(posedge clock) begin
      bit          accepted_now;
      bit          hold_for_drain;
      int unsigned next_index;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         accepted_now = req_valid && req_ready;
         if (accepted_now) begin
            sent_count <= sent_count + 1;
         end
         if (!req_valid || req_ready) begin
            next_index = sent_count + accepted_now;
            // At a drain point nothing new goes out until every response has come back.
            hold_for_drain = is_drain_point(next_index) && (accepted_now || !results_idle);
            if (day_stream.size() != 0 && !hold_for_drain &&
                $urandom_range(99) >= idle_percent(next_index, 1'b0)) begin
               req_valid      <= 1'b1;
               req_day_number <= day_stream.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: records predictions on request acceptance, checks responses in order.
   always @(posedge clock) begin
      date_expectation_type want;
      date_expectation_type got;
      if (reset) begin
         rsp_ready    <= 1'b0;
         results_idle <= 1'b1;
      end else begin
         if (req_valid && req_ready) begin
            got.day_number = req_day_number;
            got.date       = convert_days(req_day_number);
            pending_dates.push_back(got);
         end
         if (rsp_valid && rsp_ready) begin
            checked_count <= checked_count + 1;
            if (pending_dates.size() == 0) begin
               failures++;
               $display("%0t: unexpected transaction: year %0d month %0d day %0d", $time,
                        rsp_year, rsp_month, rsp_day_of_month);
            end else begin
               want = pending_dates.pop_front();
               if (rsp_year !== want.date.year) begin
                  failures++;
                  $display("%0t: day %0d year: expected %0d, actual %0d", $time,
                           want.day_number, want.date.year, rsp_year);
               end
               if (rsp_month !== want.date.month) begin
                  failures++;
                  $display("%0t: day %0d month: expected %0d, actual %0d", $time,
                           want.day_number, want.date.month, rsp_month);
               end
               if (rsp_day_of_month !== want.date.mday) begin
                  failures++;
                  $display("%0t: day %0d day of month: expected %0d, actual %0d", $time,
                           want.day_number, want.date.mday, rsp_day_of_month);
               end
               years_seen[want.date.year - dtcd_pkg::EPOCH_YEAR] <= 1'b1;
               if (want.date.month == 2 && want.date.mday == 29) begin
                  leap_days_seen <= leap_days_seen + 1;
               end
            end
         end
         results_idle <= (pending_dates.size() == 0);
         rsp_ready    <= ($urandom_range(99) >= idle_percent(checked_count, 1'b1));
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d transactions outstanding", $time,
                  pending_dates.size());
         $display("days_to_calendar_date regression: fail");
         $finish;
      end
   end

   initial begin
      // Calendar extremes, year and month boundaries, and the century rule.
      day_stream.push_back(16'd0);
      day_stream.push_back(16'hFFFF);
      day_stream.push_back(date_to_days(1970, 12, 31));
      day_stream.push_back(date_to_days(1971, 1, 1));
      day_stream.push_back(date_to_days(1972, 2, 28));
      day_stream.push_back(date_to_days(1972, 2, 29));
      day_stream.push_back(date_to_days(1972, 3, 1));
      day_stream.push_back(date_to_days(1972, 12, 31));
      day_stream.push_back(date_to_days(1973, 1, 1));
      day_stream.push_back(date_to_days(2000, 2, 29));
      day_stream.push_back(date_to_days(2000, 12, 31));
      day_stream.push_back(date_to_days(2099, 12, 31));
      day_stream.push_back(date_to_days(2100, 2, 28));
      day_stream.push_back(date_to_days(2100, 3, 1));
      day_stream.push_back(date_to_days(2149, 1, 1));
      day_stream.push_back(16'h5555);
      day_stream.push_back(16'hAAAA);
      day_stream.push_back(date_to_days(1999, 4, 30));
      day_stream.push_back(date_to_days(1988, 5, 31));
      day_stream.push_back(date_to_days(2023, 7, 31));
      day_stream.push_back(date_to_days(2024, 8, 31));
      day_stream.push_back(date_to_days(2050, 9, 30));
      day_stream.push_back(date_to_days(2030, 10, 1));
      day_stream.push_back(date_to_days(2011, 11, 30));
      directed_items = day_stream.size();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         day_stream.push_back(random_day_number());
      end
      total_items = day_stream.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (day_stream.size() != 0 || req_valid || !results_idle) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (pending_dates.size() != 0) begin
         failures++;
         $display("%0t: %0d expected transactions never arrived", $time, pending_dates.size());
      end
      $display("Converted %0d day counts (%0d directed) under three handshake stall mixes,",
               checked_count, directed_items);
      $display("reaching %0d of %0d years and %0d leap days.", $countones(years_seen),
               YEAR_SPAN, leap_days_seen);
      if (failures == 0) begin
         $display("days_to_calendar_date regression: pass");
      end else begin
         $display("days_to_calendar_date regression: fail");
      end
      $finish;
   end

endmodule
